>>> hdl/mcvs_pkg.sv
// Shared constants and types of the minimal-congestion VC selector.
`timescale 1ns / 1ps

package mcvs_pkg;

   // Lane count and derived widths
   localparam int MAX_VCS    = 8;
   localparam int LANE_W     = (MAX_VCS > 1) ? $clog2(MAX_VCS) : 1;
   localparam int TREE_LVLS  = $clog2(MAX_VCS);
   localparam int TREE_N     = 1 << TREE_LVLS;

   // Field widths
   localparam int NUM_CONG   = 8;
   localparam int CONG_W     = 16;
   localparam int PORT_W     = 8;
   localparam int VC_W       = 8;
   localparam int CNT_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CONG_W-1:0] CONG_MAX = '1;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ADAPTIVE_MODE = 2'd0,
      CSR_BASE_VC       = 2'd1,
      CSR_NUM_VCS       = 2'd2,
      CSR_PORT_COUNT    = 2'd3
   } csr_index_type;

   // Per-lane control shared by all lanes
   typedef struct packed {
      logic             adaptive;
      logic [CNT_W-1:0] lane_count;
   } mcvs_ctl_type;

   // One request handed to the emitter
   typedef struct packed {
      logic [PORT_W-1:0]  port;
      logic               err;
      logic [MAX_VCS-1:0] mask;
   } mcvs_load_type;

endpackage

>>> hdl/mcvs_lane.sv
// One congestion lane: holds its value, masks inactive lanes, flags selection.
`timescale 1ns / 1ps

module mcvs_lane import mcvs_pkg::*; (
   input  logic              clock,
   input  logic              load,
   input  logic [LANE_W-1:0] lane_idx,
   input  logic [CONG_W-1:0] cong_in,
   input  mcvs_ctl_type      ctl,
   input  logic [CONG_W-1:0] min_cong,
   output logic [CONG_W-1:0] eff_cong,
   output logic              sel
);

   logic [CONG_W-1:0] cong_ff;
   logic [CONG_W-1:0] cong_in_d;
   logic              active;

   assign cong_in_d = load ? cong_in : cong_ff;

   always_ff @(posedge clock) begin
      cong_ff <= cong_in_d;
   end

   assign active   = CNT_W'(lane_idx) < ctl.lane_count;
   // inactive lanes never pull the minimum down
   assign eff_cong = active ? cong_ff : CONG_MAX;
   assign sel      = active && (!ctl.adaptive || (cong_ff == min_cong));

endmodule

>>> hdl/mcvs_min_tree.sv
// Binary minimum tree that merges the lane congestion values.
`timescale 1ns / 1ps

module mcvs_min_tree import mcvs_pkg::*; (
   input  logic [CONG_W-1:0] lane_cong [MAX_VCS],
   output logic [CONG_W-1:0] min_cong
);

   logic [CONG_W-1:0] node [2*TREE_N-1];

   for (genvar l = 0; l < TREE_N; l++) begin : g_leaf
      if (l < MAX_VCS) begin : g_used
         assign node[TREE_N-1+l] = lane_cong[l];
      end else begin : g_pad
         assign node[TREE_N-1+l] = CONG_MAX;
      end
   end

   for (genvar k = 0; k < TREE_N - 1; k++) begin : g_node
      assign node[k] = (node[2*k+2] < node[2*k+1]) ? node[2*k+2] : node[2*k+1];
   end

   assign min_cong = node[0];

endmodule

>>> hdl/mcvs_emitter.sv
// Serializes the selected lanes of one request into result strobes.
`timescale 1ns / 1ps

module mcvs_emitter import mcvs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              load_valid,
   input  mcvs_load_type     load_data,
   input  logic [VC_W-1:0]   base_vc,
   output logic              can_load,
   output logic              rsp_valid,
   output logic [PORT_W-1:0] rsp_out_port,
   output logic [VC_W-1:0]   rsp_out_vc,
   output logic              rsp_last,
   output logic              rsp_port_error
);

   logic [MAX_VCS-1:0] mask_ff, mask_in;
   logic               err_ff, err_in;
   logic [PORT_W-1:0]  port_ff, port_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PORT_W-1:0]  rsp_port_ff, rsp_port_in;
   logic [VC_W-1:0]    rsp_vc_ff, rsp_vc_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_err_ff, rsp_err_in;

   logic               pending;
   logic               is_last;
   logic [MAX_VCS-1:0] rest;
   logic [LANE_W-1:0]  pick;

   // lowest selected lane first
   always_comb begin
      pick = '0;
      for (int i = MAX_VCS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            pick = LANE_W'(i);
         end
      end
   end

   assign pending  = (|mask_ff) || err_ff;
   assign rest     = mask_ff & (mask_ff - 1'b1);
   assign is_last  = err_ff || (rest == '0);
   assign can_load = !pending || is_last;

   always_comb begin
      rsp_valid_in = pending;
      rsp_port_in  = port_ff;
      rsp_vc_in    = err_ff ? '0 : base_vc + VC_W'(pick);
      rsp_last_in  = is_last;
      rsp_err_in   = err_ff;
      mask_in      = rest;
      err_in       = 1'b0;
      port_in      = port_ff;
      if (load_valid && can_load) begin
         mask_in = load_data.mask;
         err_in  = load_data.err;
         port_in = load_data.port;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      port_ff     <= port_in;
      rsp_port_ff <= rsp_port_in;
      rsp_vc_ff   <= rsp_vc_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_port   = rsp_port_ff;
   assign rsp_out_vc     = rsp_vc_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_port_error = rsp_err_ff;

endmodule

>>> hdl/min_congestion_vc_select.sv
// Top level of the minimal-congestion virtual channel selector.
//
//   channel  | ports                                  | handshake
//   ---------+----------------------------------------+---------------------------
//   request  | req_dest_port, req_cong_0..7           | taken when start && !busy
//   result   | rsp_out_port, rsp_out_vc, rsp_last,    | rsp_valid for one cycle,
//            | rsp_port_error                         | always taken
//   csr      | csr_we, csr_index, csr_wdata           | written when csr_we
//
// The emitter sends one result per cycle for each request, which has up to eight
// candidates. The first result passes the input stage register, the emitter's mask
// register and its output register.
// The next request is taken while the emitter still works on the current one; busy
// rises only when the input stage is full and the emitter is not on its last result.
// Reset is synchronous and restores the registers to adaptive_mode 0, base_vc 0,
// num_vcs 8, port_count 16. The receiver cannot stall the result channel.
`timescale 1ns / 1ps

module min_congestion_vc_select import mcvs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [PORT_W-1:0]    req_dest_port,
   input  logic [CONG_W-1:0]    req_cong_0,
   input  logic [CONG_W-1:0]    req_cong_1,
   input  logic [CONG_W-1:0]    req_cong_2,
   input  logic [CONG_W-1:0]    req_cong_3,
   input  logic [CONG_W-1:0]    req_cong_4,
   input  logic [CONG_W-1:0]    req_cong_5,
   input  logic [CONG_W-1:0]    req_cong_6,
   input  logic [CONG_W-1:0]    req_cong_7,
   output logic                 rsp_valid,
   output logic [PORT_W-1:0]    rsp_out_port,
   output logic [VC_W-1:0]      rsp_out_vc,
   output logic                 rsp_last,
   output logic                 rsp_port_error,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   logic               adaptive_ff, adaptive_in;
   logic [VC_W-1:0]    base_vc_ff, base_vc_in;
   logic [CNT_W-1:0]   num_vcs_ff, num_vcs_in;
   logic [PORT_W-1:0]  port_count_ff, port_count_in;

   // Input stage
   logic               a_valid_ff, a_valid_in;
   logic [PORT_W-1:0]  a_port_ff, a_port_in;
   logic               accept;
   logic               can_load;

   logic [CONG_W-1:0]  req_cong [NUM_CONG];
   logic [CONG_W-1:0]  lane_cong [MAX_VCS];
   logic [MAX_VCS-1:0] lane_sel;
   logic [CONG_W-1:0]  min_cong;
   mcvs_ctl_type       ctl;
   mcvs_load_type      load_data;

   // Decode register writes
   always_comb begin
      adaptive_in   = adaptive_ff;
      base_vc_in    = base_vc_ff;
      num_vcs_in    = num_vcs_ff;
      port_count_in = port_count_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ADAPTIVE_MODE: adaptive_in   = csr_wdata[0];
            CSR_BASE_VC:       base_vc_in    = csr_wdata[VC_W-1:0];
            CSR_NUM_VCS:       num_vcs_in    = csr_wdata[CNT_W-1:0];
            CSR_PORT_COUNT:    port_count_in = csr_wdata[PORT_W-1:0];
            default:           adaptive_in   = adaptive_ff;
         endcase
      end
   end

   // Take a new request whenever the input stage is empty or moves on this cycle
   assign busy       = a_valid_ff && !can_load;
   assign accept     = start && !busy;
   assign a_valid_in = accept || (a_valid_ff && !can_load);
   assign a_port_in  = accept ? req_dest_port : a_port_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         adaptive_ff   <= 1'b0;
         base_vc_ff    <= '0;
         num_vcs_ff    <= CNT_W'(8);
         port_count_ff <= PORT_W'(16);
         a_valid_ff    <= 1'b0;
      end else begin
         adaptive_ff   <= adaptive_in;
         base_vc_ff    <= base_vc_in;
         num_vcs_ff    <= num_vcs_in;
         port_count_ff <= port_count_in;
         a_valid_ff    <= a_valid_in;
      end
      a_port_ff <= a_port_in;
   end

   // Clamp lane count to the lanes built
   assign ctl.adaptive   = adaptive_ff;
   assign ctl.lane_count = (num_vcs_ff > CNT_W'(MAX_VCS)) ? CNT_W'(MAX_VCS) : num_vcs_ff;

   assign req_cong[0] = req_cong_0;
   assign req_cong[1] = req_cong_1;
   assign req_cong[2] = req_cong_2;
   assign req_cong[3] = req_cong_3;
   assign req_cong[4] = req_cong_4;
   assign req_cong[5] = req_cong_5;
   assign req_cong[6] = req_cong_6;
   assign req_cong[7] = req_cong_7;

   // One lane per candidate VC
   for (genvar g = 0; g < MAX_VCS; g++) begin : g_lane
      mcvs_lane u_lane (
         .clock    (clock),
         .load     (accept),
         .lane_idx (LANE_W'(g)),
         .cong_in  (req_cong[g]),
         .ctl      (ctl),
         .min_cong (min_cong),
         .eff_cong (lane_cong[g]),
         .sel      (lane_sel[g])
      );
   end

   // Merge lane values into the minimum
   mcvs_min_tree u_min_tree (
      .lane_cong (lane_cong),
      .min_cong  (min_cong)
   );

   // Out-of-range port overrides every lane with a single error result
   assign load_data.port = a_port_ff;
   assign load_data.err  = a_port_ff >= port_count_ff;
   assign load_data.mask = load_data.err ? '0 : lane_sel;

   mcvs_emitter u_emitter (
      .clock          (clock),
      .reset          (reset),
      .load_valid     (a_valid_ff),
      .load_data      (load_data),
      .base_vc        (base_vc_ff),
      .can_load       (can_load),
      .rsp_valid      (rsp_valid),
      .rsp_out_port   (rsp_out_port),
      .rsp_out_vc     (rsp_out_vc),
      .rsp_last       (rsp_last),
      .rsp_port_error (rsp_port_error)
   );

endmodule

>>> hdl/mcvs_checker.sv
// Port-level checks of the VC selector and their attachment to the top level.
`timescale 1ns / 1ps

module mcvs_checker import mcvs_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              busy,
   input logic              rsp_valid,
   input logic [PORT_W-1:0] rsp_out_port,
   input logic [VC_W-1:0]   rsp_out_vc,
   input logic              rsp_last,
   input logic              rsp_port_error
);

   // Results of one transaction come back to back
   a_burst_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("result burst broken before last");

   // Same port through a burst, never an error inside one
   a_burst_port: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_out_port == $past(rsp_out_port) && !rsp_port_error)
      else $error("port changed inside a result burst");

   // An error is a single result with VC zero
   a_error_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_port_error |-> rsp_last && rsp_out_vc == '0)
      else $error("port error result malformed");

   // Reset leaves the block quiet
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy)
      else $error("activity right after reset");

endmodule

bind min_congestion_vc_select mcvs_checker u_mcvs_checker (
   .clock          (clock),
   .reset          (reset),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_out_port   (rsp_out_port),
   .rsp_out_vc     (rsp_out_vc),
   .rsp_last       (rsp_last),
   .rsp_port_error (rsp_port_error)
);

>>> dv/mcvs_route_checker.sv
// Checker for the VC selector: mirrors registers, predicts route candidates, compares results.
`timescale 1ns / 1ps

module mcvs_route_checker
   import mcvs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [PORT_W-1:0]     req_dest_port,
   input  logic [CONG_W-1:0]     req_cong_0,
   input  logic [CONG_W-1:0]     req_cong_1,
   input  logic [CONG_W-1:0]     req_cong_2,
   input  logic [CONG_W-1:0]     req_cong_3,
   input  logic [CONG_W-1:0]     req_cong_4,
   input  logic [CONG_W-1:0]     req_cong_5,
   input  logic [CONG_W-1:0]     req_cong_6,
   input  logic [CONG_W-1:0]     req_cong_7,
   input  logic                  rsp_valid,
   input  logic [PORT_W-1:0]     rsp_out_port,
   input  logic [VC_W-1:0]       rsp_out_vc,
   input  logic                  rsp_last,
   input  logic                  rsp_port_error,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    pending,
   output int                    errors
);

   typedef struct packed {
      logic [PORT_W-1:0] port;
      logic [VC_W-1:0]   vc;
      logic              last;
      logic              err;
   } route_type;

   route_type pending_routes[$];

   logic              adaptive_r;
   logic [VC_W-1:0]   base_vc_r;
   logic [CNT_W-1:0]  num_vcs_r;
   logic [PORT_W-1:0] port_count_r;

   int mismatch_count = 0;

   assign errors = mismatch_count;

   initial pending = 0;

   // Queue up every route candidate that one request should produce.
   function automatic void compute_routes(input logic [PORT_W-1:0] port,
                                          input logic [NUM_CONG*CONG_W-1:0] cong);
      int               lanes;
      int               hits;
      int               k;
      int               i;
      logic [CONG_W-1:0] lowest;
      logic [VC_W-1:0]  offs;
      route_type        r;
      if (port >= port_count_r) begin
         r.port = port;
         r.vc   = '0;
         r.last = 1'b1;
         r.err  = 1'b1;
         pending_routes.insert(pending_routes.size(), r);
         return;
      end
      lanes  = (num_vcs_r > MAX_VCS) ? MAX_VCS : int'(num_vcs_r);
      lowest = CONG_MAX;
      for (i = 0; i < lanes; i++)
         if (cong[i*CONG_W +: CONG_W] < lowest) lowest = cong[i*CONG_W +: CONG_W];
      hits = 0;
      for (i = 0; i < lanes; i++)
         if (!adaptive_r || cong[i*CONG_W +: CONG_W] == lowest) hits++;
      k = 0;
      for (i = 0; i < lanes; i++) begin
         if (!adaptive_r || cong[i*CONG_W +: CONG_W] == lowest) begin
            k++;
            offs   = VC_W'(i);
            r.port = port;
            r.vc   = base_vc_r + offs;
            r.last = (k == hits);
            r.err  = 1'b0;
            pending_routes.insert(pending_routes.size(), r);
         end
      end
   endfunction

   always @(posedge clock) begin
      route_type want;
      if (reset) begin
         adaptive_r   <= 1'b0;
         base_vc_r    <= '0;
         num_vcs_r    <= CNT_W'(8);
         port_count_r <= PORT_W'(16);
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ADAPTIVE_MODE: adaptive_r   <= csr_wdata[0];
               CSR_BASE_VC:       base_vc_r    <= csr_wdata;
               CSR_NUM_VCS:       num_vcs_r    <= csr_wdata[CNT_W-1:0];
               CSR_PORT_COUNT:    port_count_r <= csr_wdata;
               default: ;
            endcase
         end
         // Compare results first so a same-edge transaction cannot match a stale result.
         if (rsp_valid) begin
            if (pending_routes.size() == 0) begin
               $display("%0t: expected no result, got port %0d vc %0d last %0b err %0b",
                        $time, rsp_out_port, rsp_out_vc, rsp_last, rsp_port_error);
               mismatch_count++;
            end else begin
               want = pending_routes.pop_front();
               if (rsp_out_port !== want.port) begin
                  $display("%0t: out_port expected %0d, got %0d", $time, want.port,
                           rsp_out_port);
                  mismatch_count++;
               end
               if (rsp_out_vc !== want.vc) begin
                  $display("%0t: out_vc expected %0d, got %0d", $time, want.vc, rsp_out_vc);
                  mismatch_count++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last expected %0b, got %0b", $time, want.last, rsp_last);
                  mismatch_count++;
               end
               if (rsp_port_error !== want.err) begin
                  $display("%0t: port_error expected %0b, got %0b", $time, want.err,
                           rsp_port_error);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy)
            compute_routes(req_dest_port, {req_cong_7, req_cong_6, req_cong_5, req_cong_4,
                                           req_cong_3, req_cong_2, req_cong_1, req_cong_0});
      end
      pending <= pending_routes.size();
   end

endmodule

>>> dv/tb_min_congestion_vc_select.sv
// Testbench top for the VC selector: register phases, directed and random requests, verdict.
`timescale 1ns / 1ps

module tb_min_congestion_vc_select import mcvs_pkg::*; ();

   // Cycles to let pass once nothing is expected: covers the registered result path,
   // a full emitter and a zero-lane request still in flight.
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASE_ITEMS  = 9;
   localparam int NUM_PHASES   = 10;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  start          = 1'b0;
   logic [PORT_W-1:0]     req_dest_port  = '0;
   logic [CONG_W-1:0]     req_cong_0     = '0;
   logic [CONG_W-1:0]     req_cong_1     = '0;
   logic [CONG_W-1:0]     req_cong_2     = '0;
   logic [CONG_W-1:0]     req_cong_3     = '0;
   logic [CONG_W-1:0]     req_cong_4     = '0;
   logic [CONG_W-1:0]     req_cong_5     = '0;
   logic [CONG_W-1:0]     req_cong_6     = '0;
   logic [CONG_W-1:0]     req_cong_7     = '0;
   logic                  csr_we         = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index      = CSR_ADAPTIVE_MODE;
   logic [CSR_DATA_W-1:0] csr_wdata      = '0;

   logic                  busy;
   logic                  rsp_valid;
   logic [PORT_W-1:0]     rsp_out_port;
   logic [VC_W-1:0]       rsp_out_vc;
   logic                  rsp_last;
   logic                  rsp_port_error;

   int pending;
   int errors;

   // Sender pacing state: start_on shadows the last value given to start, so that start
   // never gets two nonblocking assignments in one time step.
   logic start_on    = 1'b0;
   logic steady      = 1'b0;
   int   burst_left  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   min_congestion_vc_select dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_dest_port (req_dest_port),
      .req_cong_0    (req_cong_0),
      .req_cong_1    (req_cong_1),
      .req_cong_2    (req_cong_2),
      .req_cong_3    (req_cong_3),
      .req_cong_4    (req_cong_4),
      .req_cong_5    (req_cong_5),
      .req_cong_6    (req_cong_6),
      .req_cong_7    (req_cong_7),
      .rsp_valid     (rsp_valid),
      .rsp_out_port  (rsp_out_port),
      .rsp_out_vc    (rsp_out_vc),
      .rsp_last      (rsp_last),
      .rsp_port_error(rsp_port_error),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   mcvs_route_checker u_route_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_dest_port (req_dest_port),
      .req_cong_0    (req_cong_0),
      .req_cong_1    (req_cong_1),
      .req_cong_2    (req_cong_2),
      .req_cong_3    (req_cong_3),
      .req_cong_4    (req_cong_4),
      .req_cong_5    (req_cong_5),
      .req_cong_6    (req_cong_6),
      .req_cong_7    (req_cong_7),
      .rsp_valid     (rsp_valid),
      .rsp_out_port  (rsp_out_port),
      .rsp_out_vc    (rsp_out_vc),
      .rsp_last      (rsp_last),
      .rsp_port_error(rsp_port_error),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .pending       (pending),
      .errors        (errors)
   );

   // Write all four registers on consecutive edges; only called while the block is idle.
   // Junk in the unused upper data bits must be dropped by the block.
   task automatic program_regs(input logic adaptive, input logic [VC_W-1:0] base,
                               input logic [CNT_W-1:0] lanes, input logic [PORT_W-1:0] ports);
      logic [CSR_DATA_W-1:0] junk;
      junk      = CSR_DATA_W'($urandom);
      csr_we    <= 1'b1;
      csr_index <= CSR_ADAPTIVE_MODE;
      csr_wdata <= {junk[CSR_DATA_W-1:1], adaptive};
      @(posedge clock);
      csr_index <= CSR_BASE_VC;
      csr_wdata <= base;
      @(posedge clock);
      csr_index <= CSR_NUM_VCS;
      csr_wdata <= {junk[CSR_DATA_W-1:CNT_W], lanes};
      @(posedge clock);
      csr_index <= CSR_PORT_COUNT;
      csr_wdata <= ports;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Insert a random gap once the current burst runs out; steady phases never idle.
   task automatic pace();
      int gap;
      if (steady) return;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(0, 6);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
         start    <= 1'b0;
         start_on  = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Present one request and hold it until the block takes the transaction.
   task automatic send_request(input logic [PORT_W-1:0] port,
                               input logic [NUM_CONG*CONG_W-1:0] cong);
      req_dest_port <= port;
      req_cong_0    <= cong[0*CONG_W +: CONG_W];
      req_cong_1    <= cong[1*CONG_W +: CONG_W];
      req_cong_2    <= cong[2*CONG_W +: CONG_W];
      req_cong_3    <= cong[3*CONG_W +: CONG_W];
      req_cong_4    <= cong[4*CONG_W +: CONG_W];
      req_cong_5    <= cong[5*CONG_W +: CONG_W];
      req_cong_6    <= cong[6*CONG_W +: CONG_W];
      req_cong_7    <= cong[7*CONG_W +: CONG_W];
      if (!start_on) begin
         start    <= 1'b1;
         start_on  = 1'b1;
      end
      @(posedge clock);
      while (busy) @(posedge clock);
      pace();
   endtask

   // Draw a request: mostly valid ports, congestion shaped to produce ties and near-ties.
   task automatic send_random(input logic [PORT_W-1:0] ports);
      logic [PORT_W-1:0]          port;
      logic [NUM_CONG*CONG_W-1:0] cong;
      logic [CONG_W-1:0]          floor_val;
      int                         style;
      int                         i;
      style     = $urandom_range(0, 4);
      floor_val = CONG_W'($urandom);
      if (ports == 0 || $urandom_range(0, 4) == 0)
         port = PORT_W'($urandom_range(0, 255));
      else
         port = PORT_W'($urandom_range(0, ports - 1));
      for (i = 0; i < NUM_CONG; i++) begin
         case (style)
            0:       cong[i*CONG_W +: CONG_W] = CONG_W'($urandom);
            1:       cong[i*CONG_W +: CONG_W] = CONG_W'($urandom_range(0, 3));
            2:       cong[i*CONG_W +: CONG_W] = $urandom_range(0, 1) ? CONG_MAX : '0;
            3:       cong[i*CONG_W +: CONG_W] = CONG_W'(CONG_MAX - $urandom_range(0, 15));
            default: cong[i*CONG_W +: CONG_W] = CONG_W'(floor_val + $urandom_range(0, 2));
         endcase
      end
      send_request(port, cong);
   endtask

   // Wait until every expected result is in, then let the block settle.
   task automatic drain();
      if (start_on) begin
         start    <= 1'b0;
         start_on  = 1'b0;
      end
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Hand-picked requests for each fixed register setting.
   task automatic send_directed(input int phase);
      logic [NUM_CONG*CONG_W-1:0] cong;
      case (phase)
         0: begin
            // Direct mode with reset values: field extremes and the port boundary.
            send_request(8'd0, {NUM_CONG{16'h0000}});
            send_request(8'd15, {NUM_CONG{CONG_MAX}});
            send_request(8'd16, {NUM_CONG{16'h5A5A}});
            send_request(8'd255, {NUM_CONG{16'hA5A5}});
         end
         1: begin
            // Adaptive: all tied, all at the ceiling, lone minimum at either end.
            send_request(8'd3, {NUM_CONG{16'h1234}});
            send_request(8'd4, {NUM_CONG{CONG_MAX}});
            cong = {NUM_CONG{CONG_MAX}};
            cong[7*CONG_W +: CONG_W] = '0;
            send_request(8'd5, cong);
            cong = {NUM_CONG{16'h8000}};
            cong[0*CONG_W +: CONG_W] = 16'h7FFF;
            send_request(8'd6, cong);
            cong = {NUM_CONG{16'd100}};
            cong[2*CONG_W +: CONG_W] = 16'd7;
            cong[5*CONG_W +: CONG_W] = 16'd7;
            send_request(8'd7, cong);
            send_request(8'd9, {NUM_CONG/2{16'h5555, 16'hAAAA}});
            send_request(8'd16, {NUM_CONG{16'h0001}});
         end
         2: begin
            // VC index wraps past 255; top port is out of range.
            send_request(8'd254, {NUM_CONG{16'h0042}});
            send_request(8'd255, {NUM_CONG{16'h0042}});
         end
         3: begin
            // Lanes above num_vcs carry smaller values and must be ignored.
            cong = '0;
            cong[0*CONG_W +: CONG_W] = 16'd9;
            cong[1*CONG_W +: CONG_W] = 16'd4;
            cong[2*CONG_W +: CONG_W] = 16'd4;
            send_request(8'd99, cong);
         end
         4: begin
            send_request(8'd0, {NUM_CONG{16'hFFFE}});
            send_request(8'd1, {NUM_CONG{16'hFFFE}});
         end
         5: begin
            // Zero lanes: no result for a valid port, an error result otherwise.
            send_request(8'd2, {NUM_CONG{16'h0003}});
            send_request(8'd8, {NUM_CONG{16'h0003}});
         end
         6: begin
            // Lane count beyond eight saturates.
            cong = {NUM_CONG{16'h0200}};
            cong[7*CONG_W +: CONG_W] = 16'h01FF;
            send_request(8'd199, cong);
         end
         7: begin
            // Zero port count: every destination is an error.
            send_request(8'd0, {NUM_CONG{16'h0000}});
         end
         default: ;
      endcase
   endtask

   initial begin
      logic              adaptive;
      logic [VC_W-1:0]   base;
      logic [CNT_W-1:0]  lanes;
      logic [PORT_W-1:0] ports;
      int                phase;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         // Phase zero runs on the reset values; later phases reprogram while idle.
         case (phase)
            0: begin adaptive = 1'b0; base = 8'd0;   lanes = 4'd8;  ports = 8'd16;  end
            1: begin adaptive = 1'b1; base = 8'd0;   lanes = 4'd8;  ports = 8'd16;  end
            2: begin adaptive = 1'b1; base = 8'd250; lanes = 4'd8;  ports = 8'd255; end
            3: begin adaptive = 1'b1; base = 8'd5;   lanes = 4'd3;  ports = 8'd100; end
            4: begin adaptive = 1'b0; base = 8'd247; lanes = 4'd1;  ports = 8'd1;   end
            5: begin adaptive = 1'b0; base = 8'd0;   lanes = 4'd0;  ports = 8'd8;   end
            6: begin adaptive = 1'b1; base = 8'd100; lanes = 4'd12; ports = 8'd200; end
            7: begin adaptive = 1'b0; base = 8'd255; lanes = 4'd15; ports = 8'd0;   end
            default: begin
               adaptive = 1'($urandom_range(0, 1));
               base     = VC_W'($urandom);
               lanes    = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 15))
                                                      : CNT_W'($urandom_range(1, 8));
               ports    = PORT_W'($urandom_range(1, 255));
            end
         endcase
         if (phase > 0) program_regs(adaptive, base, lanes, ports);
         steady = (phase == 2 || phase == 6);
         send_directed(phase);
         repeat (PHASE_ITEMS) send_random(ports);
         drain();
      end

      if (errors == 0 && pending == 0)
         $display("tb_min_congestion_vc_select: done, clean");
      else
         $display("tb_min_congestion_vc_select: done, errors");
      $finish;
   end

   // Stop a hung run well past the slowest legal finish.
   initial begin
      #5_000_000;
      $display("tb_min_congestion_vc_select: done, errors");
      $finish;
   end

endmodule

>>> filelist.f
hdl/mcvs_pkg.sv
hdl/mcvs_lane.sv
hdl/mcvs_min_tree.sv
hdl/mcvs_emitter.sv
hdl/min_congestion_vc_select.sv
hdl/mcvs_checker.sv
dv/mcvs_route_checker.sv
dv/tb_min_congestion_vc_select.sv
